// ===== rtl/mlpq_pkg.sv =====
package mlpq_pkg;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned LevelW  = 4;
  localparam int unsigned StatusW = 2;

  // in-tdata: value, level; out-tdata: data_out
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutUserW = StatusW + 1;

  typedef enum logic [CmdW-1:0] {
    CmdEnqueue = 2'd0,
    CmdDequeue = 2'd1,
    CmdPeek    = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StOk       = 2'd0,
    StBadLevel = 2'd1,
    StFull     = 2'd2,
    StEmpty    = 2'd3
  } status_e;

endpackage

// ===== rtl/multilevel_priority_queue.sv =====
// each transaction passes the input register, then the state update and entry store
// read, then the output register, before its result is presented
// throughput: one transaction per cycle on each side while the output is not stalled;
// three items can be held, so the input keeps flowing under an output stall until all fill
// reset: heads, tails, counts and all valid bits clear; entry store is not reset
module multilevel_priority_queue
  import mlpq_pkg::*;
#(
  parameter int unsigned LEVELS      = 10,
  parameter int unsigned LEVEL_DEPTH = 16,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // value[31:0], level[35:32], zero pad
  input  logic [CmdW-1:0]     s_axis_tuser_i,   // cmd[1:0]
  // result stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [ValueW-1:0]   m_axis_tdata_o,   // data_out[31:0]
  output logic [OutUserW-1:0] m_axis_tuser_o    // status[1:0], all_empty[2]
);

  localparam int unsigned SlotW    = (LEVEL_DEPTH > 2) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int unsigned CntW     = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned LvlW     = $clog2(LEVELS);
  localparam int unsigned AddrW    = LvlW + SlotW;
  localparam int unsigned MemDepth = LEVELS << SlotW;

  // ---------------------------------------------------------------------------
  // handshake chain: input reg -> state/store stage -> output reg
  // ---------------------------------------------------------------------------
  logic s0_valid_q, s1_valid_q, out_valid_q;
  logic out_free, s1_move, s1_free, s0_move, s0_load;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s1_move         = s1_valid_q && out_free;
  assign s1_free         = !s1_valid_q || s1_move;
  assign s0_move         = s0_valid_q && s1_free;
  assign s_axis_tready_o = !s0_valid_q || s0_move;
  assign s0_load         = s_axis_tvalid_i && s_axis_tready_o;

  // input register
  cmd_e              s0_cmd_q;
  logic [ValueW-1:0] s0_value_q;
  logic [LevelW-1:0] s0_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s0_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_load) begin
      s0_cmd_q   <= cmd_e'(s_axis_tuser_i);
      s0_value_q <= s_axis_tdata_i[ValueW-1:0];
      s0_level_q <= s_axis_tdata_i[ValueW +: LevelW];
    end
  end

  // ---------------------------------------------------------------------------
  // per-level fifo control state
  // ---------------------------------------------------------------------------
  logic [CntW-1:0]  count_q [LEVELS];
  logic [CntW-1:0]  count_d [LEVELS];
  logic [SlotW-1:0] head_q  [LEVELS];
  logic [SlotW-1:0] head_d  [LEVELS];
  logic [SlotW-1:0] tail_q  [LEVELS];
  logic [SlotW-1:0] tail_d  [LEVELS];

  logic [LEVELS-1:0] nonempty, full;
  logic [LvlW-1:0]   top_lvl, lvl_idx;
  logic              any_nonempty, level_ok;
  logic              is_enq, is_read, enq_ok, rd_en, deq_ok;
  status_e           status;
  logic              all_empty_after;

  function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] s);
    logic [SlotW-1:0] r;
    r = (s == SlotW'(LEVEL_DEPTH - 1)) ? '0 : s + 1'b1;
    return r;
  endfunction

  // full / non-empty flags per level, then a priority encoder for the top
  always_comb begin
    top_lvl = '0;
    for (int i = 0; i < LEVELS; i++) begin
      nonempty[i] = (count_q[i] != '0);
      full[i]     = (count_q[i] == CntW'(LEVEL_DEPTH));
      if (nonempty[i]) begin
        top_lvl = LvlW'(i);
      end
    end
  end

  assign any_nonempty = |nonempty;
  assign lvl_idx      = s0_level_q[LvlW-1:0];
  assign level_ok     = {1'b0, s0_level_q} < (LevelW + 1)'(LEVELS);

  // command decode and status
  always_comb begin
    is_enq  = 1'b0;
    is_read = 1'b0;
    status  = StOk;
    unique case (s0_cmd_q)
      CmdEnqueue: begin
        is_enq = 1'b1;
        if (!level_ok) begin
          status = StBadLevel;
        end else if (full[lvl_idx]) begin
          status = StFull;
        end
      end
      CmdDequeue, CmdPeek: begin
        is_read = 1'b1;
        if (!any_nonempty) begin
          status = StEmpty;
        end
      end
      default: begin
        status = StOk;
      end
    endcase
  end

  assign enq_ok = s0_move && is_enq && (status == StOk);
  assign rd_en  = s0_move && is_read && any_nonempty;
  assign deq_ok = rd_en && (s0_cmd_q == CmdDequeue);

  // next counts and pointers, one lane per level
  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      count_d[i] = count_q[i];
      head_d[i]  = head_q[i];
      tail_d[i]  = tail_q[i];
      if (enq_ok && (lvl_idx == LvlW'(i))) begin
        count_d[i] = count_q[i] + 1'b1;
        tail_d[i]  = next_slot(tail_q[i]);
      end else if (deq_ok && (top_lvl == LvlW'(i))) begin
        count_d[i] = count_q[i] - 1'b1;
        head_d[i]  = next_slot(head_q[i]);
      end
    end
  end

  always_comb begin
    all_empty_after = 1'b1;
    for (int i = 0; i < LEVELS; i++) begin
      if (count_d[i] != '0) begin
        all_empty_after = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        count_q[i] <= '0;
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < LEVELS; i++) begin
        count_q[i] <= count_d[i];
        head_q[i]  <= head_d[i];
        tail_q[i]  <= tail_d[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // entry store: row per level, one write or one read per transaction
  // ---------------------------------------------------------------------------
  logic [DATA_WIDTH-1:0] mem [MemDepth];
  logic [DATA_WIDTH-1:0] rd_q;
  logic [AddrW-1:0]      wr_addr, rd_addr;

  assign wr_addr = {lvl_idx, tail_q[lvl_idx]};
  assign rd_addr = {top_lvl, head_q[top_lvl]};

  always_ff @(posedge clk_i) begin
    if (enq_ok) begin
      mem[wr_addr] <= DATA_WIDTH'(s0_value_q);
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // stage 1 side info, rd_q holds the matching store word
  logic    s1_hit_q, s1_empty_q;
  status_e s1_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_move) begin
      s1_hit_q    <= rd_en;
      s1_status_q <= status;
      s1_empty_q  <= all_empty_after;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic [ValueW-1:0] out_data_q;
  status_e           out_status_q;
  logic              out_empty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_data_q   <= s1_hit_q ? ValueW'(rd_q) : '0;
      out_status_q <= s1_status_q;
      out_empty_q  <= s1_empty_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = {out_empty_q, out_status_q};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_empty_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == StEmpty)) |-> out_empty_q)
    else $error("empty status without all-empty flag");

  a_err_no_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != StOk)) |-> (out_data_q == '0))
    else $error("data returned with error status");

  a_one_port : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(enq_ok && rd_en))
    else $error("store written and read by one transaction");

  a_enq_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq_ok |=> (s1_valid_q && !s1_empty_q && !s1_hit_q))
    else $error("enqueue left queue empty");

  a_read_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> (s1_valid_q && s1_hit_q && (s1_status_q == StOk)))
    else $error("store read not flagged as hit");

endmodule
